// ===== design/horner_polynomial_evaluator_macros.svh =====
// Assertion macros for the Horner polynomial evaluator.
// No dependencies; taken in by the top level with an include.
`ifndef HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hpe_pkg.sv =====
// Shared types and constants for the Horner polynomial evaluator.
// No dependencies; imported by the controller, the datapath and the top level.
package hpe_pkg;

  // Sizes of the polynomial and of the fields.
  localparam int MAX_DEGREE = 6;
  localparam int COEF_WIDTH = 16;
  localparam int NUM_COEFS  = MAX_DEGREE + 1;
  localparam int DEG_W      = 3;
  localparam int X_WIDTH    = 16;
  localparam int Y_WIDTH    = 64;
  localparam int PROD_W     = Y_WIDTH + X_WIDTH;
  localparam int IDX_W      = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;

  // Configuration port: the degree register followed by one register per coefficient.
  localparam int NUM_REGS   = NUM_COEFS + 1;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_DATA_W = (COEF_WIDTH > DEG_W) ? COEF_WIDTH : DEG_W;

  localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = CFG_IDX_W'(0);
  localparam int                   REG_COEF_BASE   = 1;

  typedef logic [NUM_COEFS-1:0][COEF_WIDTH-1:0] coef_vec_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } hpe_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic             add_en;
    logic             out_load;
    logic [IDX_W-1:0] coef_idx;
  } hpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } hpe_sts_t;

endpackage

// ===== design/hpe_ctrl.sv =====
// Controller of the Horner evaluator: sequences the multiply and add steps.
// Depends on hpe_pkg for the state type and the command and status structs.
module hpe_ctrl import hpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DEG_W-1:0] poly_degree,
  input  hpe_sts_t         sts,
  output hpe_cmd_t         cmd
);

  hpe_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] eff_degree;

  // Degrees above the maximum are saturated.
  assign eff_degree = (32'(poly_degree) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE)
                                                      : IDX_W'(poly_degree);

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = (cnt_r == '0) ? ST_DONE : ST_MUL;
      ST_DONE: if (!sts.out_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Step counter: loaded with the degree, counted down after each add.
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_IDLE && in_valid) begin
      cnt_nxt = eff_degree;
    end else if (state_r == ST_ADD && cnt_r != '0) begin
      cnt_nxt = cnt_r - IDX_W'(1);
    end
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.add_en   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.coef_idx = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.mul_en = 1'b1;
      ST_ADD:  cmd.add_en = 1'b1;
      ST_DONE: cmd.out_load = !sts.out_full;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ===== design/hpe_datapath.sv =====
// Datapath of the Horner evaluator: multiplier, adder, overflow tracking and output register.
// Depends on hpe_pkg for widths and the command and status structs.
module hpe_datapath import hpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hpe_cmd_t                  cmd,
  output hpe_sts_t                  sts,
  input  logic signed [X_WIDTH-1:0] in_x_value,
  input  coef_vec_t                 coefs,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [Y_WIDTH-1:0] out_y_value,
  output logic                      out_overflow
);

  logic signed [X_WIDTH-1:0] x_r;
  logic signed [Y_WIDTH-1:0] y_r;
  logic signed [Y_WIDTH-1:0] prod_r;
  logic                      ovf_r;
  logic signed [Y_WIDTH-1:0] out_y_r;
  logic                      out_ovf_r;
  logic                      out_valid_r;

  logic signed [PROD_W-1:0]  prod_full;
  logic                      mul_ovf;
  logic [COEF_WIDTH-1:0]     coef_sel;
  logic signed [Y_WIDTH-1:0] coef_ext;
  logic signed [Y_WIDTH-1:0] sum;
  logic                      add_ovf;

  // Full-width product; it fits 64 bits only if the top bits all copy the sign.
  assign prod_full = PROD_W'(y_r) * PROD_W'(x_r);
  assign mul_ovf   = !((&prod_full[PROD_W-1:Y_WIDTH-1]) || !(|prod_full[PROD_W-1:Y_WIDTH-1]));

  // Coefficient of the current step, sign-extended, and the wrapped sum.
  assign coef_sel = coefs[cmd.coef_idx];
  assign coef_ext = {{(Y_WIDTH-COEF_WIDTH){coef_sel[COEF_WIDTH-1]}}, coef_sel};
  assign sum      = prod_r + coef_ext;
  assign add_ovf  = (~(prod_r[Y_WIDTH-1] ^ coef_ext[Y_WIDTH-1]))
                  & (prod_r[Y_WIDTH-1] ^ sum[Y_WIDTH-1]);

  // Accumulator, product register and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_x_value;
      y_r   <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.mul_en) begin
      prod_r <= prod_full[Y_WIDTH-1:0];
      ovf_r  <= ovf_r | mul_ovf;
    end else if (cmd.add_en) begin
      y_r   <= sum;
      ovf_r <= ovf_r | add_ovf;
    end
  end

  // Output register; it holds the finished beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_y_r   <= y_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign sts.out_full = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_y_value  = out_y_r;
  assign out_overflow = out_ovf_r;

endmodule

// ===== design/horner_polynomial_evaluator.sv =====
// Horner polynomial evaluator, top level: configuration registers, controller and datapath.
// Each accepted point runs one multiply step and one add step per coefficient, d + 1 of them
// for d the saturated degree, on the single shared multiplier; no new point is taken until
// the result is loaded, and loading waits while the output register is still full.
// A finished beat waits in the output register; the next point is taken meanwhile.
// Reset (synchronous, active low) clears the degree, all coefficients and the control state.
`include "horner_polynomial_evaluator_macros.svh"

module horner_polynomial_evaluator import hpe_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [X_WIDTH-1:0]    in_x_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [Y_WIDTH-1:0]    out_y_value,
  output logic                         out_overflow
);

  logic [DEG_W-1:0] poly_degree_r;
  coef_vec_t        coef_r;
  hpe_cmd_t         cmd;
  hpe_sts_t         sts;

  // Degree register; other indexes leave it alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_degree_r <= '0;
    end else if (cfg_we && cfg_index == REG_POLY_DEGREE) begin
      poly_degree_r <= cfg_wdata[DEG_W-1:0];
    end
  end

  // One register per coefficient; writes beyond the list are ignored.
  for (genvar i = 0; i < NUM_COEFS; i++) begin : g_coef
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[i] <= '0;
      end else if (cfg_we && cfg_index == CFG_IDX_W'(REG_COEF_BASE + i)) begin
        coef_r[i] <= cfg_wdata[COEF_WIDTH-1:0];
      end
    end
  end

  hpe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .poly_degree (poly_degree_r),
    .sts         (sts),
    .cmd         (cmd)
  );

  hpe_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_x_value   (in_x_value),
    .coefs        (coef_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_y_value  (out_y_value),
    .out_overflow (out_overflow)
  );

  // Once a point is taken, no other is taken until its result is out.
  `HPE_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second beat accepted while busy")
  // A new result appears only as the controller returns to idle.
  `HPE_ASSERT_SAME(a_result_at_idle, clk, rst_n, $rose(out_valid), in_ready, "result loaded while busy")
  // The step counter never points past the highest coefficient.
  `HPE_ASSERT_SAME(a_idx_range, clk, rst_n, cmd.add_en, cmd.coef_idx <= IDX_W'(MAX_DEGREE), "coefficient index out of range")

endmodule

// ===== test/horner_checker.sv =====
// Checker for the Horner polynomial evaluator: follows register writes, predicts each point.
// Compares every result beat in order. Depends on hpe_pkg for widths and register indexes.
`timescale 1ns / 1ps

module horner_checker import hpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [X_WIDTH-1:0]        in_x_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [Y_WIDTH-1:0]        out_y_value,
  input  logic                      out_overflow,
  output int                        fail_count,
  output int                        queued_results
);

  localparam int OWED_DEPTH = 8;

  typedef struct {
    logic [Y_WIDTH-1:0] y_value;
    logic               overflow;
  } poly_result_t;

  // Local copy of the block's registers.
  logic [DEG_W-1:0]             degree_reg;
  logic signed [COEF_WIDTH-1:0] coef_regs [NUM_COEFS];

  // Values still owed by the block, oldest first, kept in a small ring.
  poly_result_t owed_values [OWED_DEPTH];
  int           owed_wr;
  int           owed_rd;

  initial begin
    fail_count     = 0;
    queued_results = 0;
    owed_wr        = 0;
    owed_rd        = 0;
  end

  // Horner's rule on 64-bit wrapping arithmetic, with a sticky flag for any product or
  // sum that leaves the signed 64-bit range.
  function automatic poly_result_t horner_eval(logic signed [X_WIDTH-1:0] x);
    poly_result_t        r;
    logic signed [127:0] prod;
    logic signed [63:0]  acc;
    logic signed [63:0]  term;
    logic signed [63:0]  coef_ext;
    logic signed [63:0]  sum;
    int                  top;
    acc = '0;
    r.overflow = 1'b0;
    top = (degree_reg > MAX_DEGREE) ? MAX_DEGREE : int'(degree_reg);
    for (int i = top; i >= 0; i--) begin
      prod = acc * x;
      if (prod[127:63] != {65{prod[63]}}) r.overflow = 1'b1;
      term = prod[63:0];
      coef_ext = coef_regs[i];
      sum = term + coef_ext;
      if (term[63] == coef_ext[63] && sum[63] != term[63]) r.overflow = 1'b1;
      acc = sum;
    end
    r.y_value = acc;
    return r;
  endfunction

  always @(posedge clk) begin
    poly_result_t want;
    if (!rst_n) begin
      degree_reg = '0;
      foreach (coef_regs[i]) coef_regs[i] = '0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        if (cfg_index == REG_POLY_DEGREE)
          degree_reg = cfg_wdata[DEG_W-1:0];
        else if (int'(cfg_index) - REG_COEF_BASE < NUM_COEFS)
          coef_regs[int'(cfg_index) - REG_COEF_BASE] = cfg_wdata[COEF_WIDTH-1:0];
      end
      // Each accepted point owes exactly one result.
      if (in_valid && in_ready) begin
        if (owed_wr - owed_rd >= OWED_DEPTH) begin
          $error("owed results: more than %0d outstanding", OWED_DEPTH);
          fail_count++;
        end else begin
          owed_values[owed_wr % OWED_DEPTH] = horner_eval(in_x_value);
          owed_wr++;
        end
      end
      // Each result beat against the oldest owed value.
      if (out_valid && out_ready) begin
        if (owed_wr == owed_rd) begin
          $error("result beat with nothing owed: y_value %0d, overflow %0b",
                 $signed(out_y_value), out_overflow);
          fail_count++;
        end else begin
          want = owed_values[owed_rd % OWED_DEPTH];
          owed_rd++;
          if (out_y_value !== want.y_value) begin
            $error("y_value: expected %0d, got %0d", $signed(want.y_value),
                   $signed(out_y_value));
            fail_count++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_overflow);
            fail_count++;
          end
        end
      end
    end
    queued_results = owed_wr - owed_rd;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the Horner polynomial evaluator bench: clock, reset, register loads and point stimulus.
// Depends on hpe_pkg, the horner_polynomial_evaluator block and horner_checker.
`timescale 1ns / 1ps

module testbench import hpe_pkg::*;;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [X_WIDTH-1:0]    in_x_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [Y_WIDTH-1:0]    out_y_value;
  logic                  out_overflow;
  int                    fail_count;
  int                    queued_results;

  logic                  gaps_on;
  int                    stall_cycles;
  logic [COEF_WIDTH-1:0] next_coefs [NUM_COEFS];

  horner_polynomial_evaluator DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_x_value   (in_x_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_y_value  (out_y_value),
    .out_overflow (out_overflow)
  );

  horner_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_value     (in_x_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_y_value    (out_y_value),
    .out_overflow   (out_overflow),
    .fail_count     (fail_count),
    .queued_results (queued_results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: a run that stops moving beats is a failure.
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Result side back-pressure: bursts of stall, and runs of steady ready between them.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  // Coefficient values: zero, extremes, small, or anything.
  function automatic logic [COEF_WIDTH-1:0] pick_coef(int style);
    case (style)
      0:       return '0;
      1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2:       return COEF_WIDTH'($urandom_range(0, 64) - 32);
      default: return COEF_WIDTH'($urandom);
    endcase
  endfunction

  // Evaluation points: extremes, small, or anything.
  function automatic logic [X_WIDTH-1:0] pick_point(int style);
    case (style)
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'hffff;
          3:       return 16'h0001;
          default: return '0;
        endcase
      end
      1:       return X_WIDTH'($urandom_range(0, 200) - 100);
      2:       return X_WIDTH'($urandom_range(0, 16) - 8);
      default: return X_WIDTH'($urandom);
    endcase
  endfunction

  // Writes the degree and every coefficient in back-to-back cycles.
  task automatic load_config(input logic [DEG_W-1:0] degree);
    cfg_we    = 1'b1;
    cfg_index = REG_POLY_DEGREE;
    cfg_wdata = CFG_DATA_W'(degree);
    @(negedge clk);
    for (int i = 0; i < NUM_COEFS; i++) begin
      cfg_index = CFG_IDX_W'(REG_COEF_BASE + i);
      cfg_wdata = CFG_DATA_W'(next_coefs[i]);
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  // Offers one point, with an optional gap before it, and returns after its beat.
  task automatic send_point(input logic [X_WIDTH-1:0] x);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_x_value = x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Lets every owed result come back before registers change.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (queued_results != 0) @(negedge clk);
  endtask

  initial begin
    int deg;
    int coef_style;
    int point_style;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_x_value = '0;
    gaps_on    = 1'b1;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Registers straight out of reset: everything evaluates to zero.
    send_point(16'h0000);
    send_point(16'h7fff);

    // Degree zero gives the constant term whatever the point.
    wait_drained();
    foreach (next_coefs[i]) next_coefs[i] = pick_coef(3);
    next_coefs[0] = 16'h8000;
    load_config(3'd0);
    send_point(16'h8000);
    send_point(16'h0005);

    // A straight line through the origin at the extremes of the point.
    wait_drained();
    foreach (next_coefs[i]) next_coefs[i] = '0;
    next_coefs[1] = 16'h0001;
    load_config(3'd1);
    send_point(16'h8000);
    send_point(16'h7fff);
    send_point(16'hffff);
    send_point(16'h0000);

    // Degree code seven falls back to six; large terms wrap and the flag stays set.
    wait_drained();
    foreach (next_coefs[i]) next_coefs[i] = 16'h7fff;
    load_config(3'd7);
    send_point(16'h7fff);
    send_point(16'h8000);

    // All coefficients at the negative extreme.
    wait_drained();
    foreach (next_coefs[i]) next_coefs[i] = 16'h8000;
    load_config(3'd6);
    send_point(16'h8000);
    send_point(16'h0001);
    send_point(16'hffff);

    // A product that lands exactly on the most negative 64-bit value is still in range.
    wait_drained();
    foreach (next_coefs[i]) next_coefs[i] = '0;
    next_coefs[4] = 16'hfff8;
    load_config(3'd4);
    send_point(16'h8000);
    send_point(16'h7fff);

    // The same product, pushed out of range by the final sum.
    wait_drained();
    next_coefs[0] = 16'hffff;
    load_config(3'd4);
    send_point(16'h8000);

    // Leading zero coefficients leave the value as for a lower degree.
    wait_drained();
    foreach (next_coefs[i]) next_coefs[i] = pick_coef(2);
    next_coefs[5] = '0;
    next_coefs[4] = '0;
    load_config(3'd5);
    send_point(pick_point(1));
    send_point(pick_point(3));
    send_point(16'h8000);

    // Random phases: a fresh register set each time, then a run of points.
    // The last phases run with no gaps on either side.
    for (int phase = 0; phase < 20; phase++) begin
      wait_drained();
      gaps_on = (phase < 16);
      case (phase)
        0:       deg = 0;
        1:       deg = 7;
        2:       deg = 6;
        default: deg = $urandom_range(0, 7);
      endcase
      coef_style = $urandom_range(0, 4);
      foreach (next_coefs[i])
        next_coefs[i] = pick_coef((coef_style == 4) ? $urandom_range(0, 3) : coef_style);
      // Now and then the upper coefficients are zero.
      if ($urandom_range(0, 3) == 0)
        for (int i = deg; i > 0 && i > deg - 2; i--)
          next_coefs[i < NUM_COEFS ? i : MAX_DEGREE] = '0;
      load_config(DEG_W'(deg));
      for (int n = 0; n < 25; n++) begin
        // Keep most high-degree points small so that in-range results are common.
        point_style = $urandom_range(0, 5);
        if (point_style > 3) point_style = (deg > 2) ? 1 : 3;
        send_point(pick_point(point_style));
      end
    end

    // Wait for every owed result, then let the block settle.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
